// ===== hw/rtl/ihs_pkg.sv =====
// Shared types, constants and helper functions of the IMU heading smoother.
package ihs_pkg;

	localparam int QUAT_WIDTH = 16;
	localparam int PROD_W     = 2 * QUAT_WIDTH;
	localparam int VEC_W      = 2 * QUAT_WIDTH + 3;
	localparam int ANG_W      = 16;
	localparam int EXT_W      = ANG_W + 2;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int ACC_W      = 28;
	localparam int ACC_SHIFT  = 11;
	localparam int TIDX_W     = 5;
	localparam int SCL_W      = GAIN_W + 1 + ANG_W;
	localparam int QDEPTH     = 2;

	localparam logic signed [EXT_W-1:0] PI_X     = 18'sd25736;
	localparam logic signed [EXT_W-1:0] TWO_PI_X = 18'sd51472;
	localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 28'sd26353589;

	localparam logic signed [ANG_W-1:0]  OFFSET_RESET = -16'sd25736;
	localparam logic        [GAIN_W-1:0] GAIN_RESET   = 16'd3277;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADING_OFFSET = 1'b0,
		REG_SMOOTHING_GAIN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] quat_x;
		logic signed [QUAT_WIDTH-1:0] quat_y;
		logic signed [QUAT_WIDTH-1:0] quat_z;
		logic signed [QUAT_WIDTH-1:0] quat_w;
	} item_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] heading;
		logic                    gimbal_lock;
	} result_t;

	// Word between front and back: yaw vector and the singularity flag
	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic                    lock;
	} vec_t;

	typedef enum logic [2:0] {
		P_WW, P_XX, P_YY, P_ZZ, P_XY, P_WZ, P_XZ, P_WY
	} prod_sel_t;

	typedef enum logic [1:0] {
		F_IDLE, F_MUL, F_DRAIN, F_CLASS
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE, B_ITER, B_ROUND, B_OFFS, B_DIFF, B_MUL, B_UPD
	} back_state_t;

	// atan(2^-i) in radians * 2^24
	function automatic logic signed [ACC_W-1:0] atan_entry(input logic [TIDX_W-1:0] i);
		logic signed [ACC_W-1:0] r;
		case (i)
			5'd0:    r = 28'sd13176795;
			5'd1:    r = 28'sd7778716;
			5'd2:    r = 28'sd4110060;
			5'd3:    r = 28'sd2086331;
			5'd4:    r = 28'sd1047214;
			5'd5:    r = 28'sd524117;
			5'd6:    r = 28'sd262123;
			5'd7:    r = 28'sd131069;
			5'd8:    r = 28'sd65536;
			5'd9:    r = 28'sd32768;
			5'd10:   r = 28'sd16384;
			5'd11:   r = 28'sd8192;
			5'd12:   r = 28'sd4096;
			5'd13:   r = 28'sd2048;
			5'd14:   r = 28'sd1024;
			5'd15:   r = 28'sd512;
			5'd16:   r = 28'sd256;
			5'd17:   r = 28'sd128;
			5'd18:   r = 28'sd64;
			5'd19:   r = 28'sd32;
			5'd20:   r = 28'sd16;
			5'd21:   r = 28'sd8;
			5'd22:   r = 28'sd4;
			5'd23:   r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// One-step wrap into [-pi, pi]; inputs never exceed one turn out of range
	function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [EXT_W-1:0] a);
		logic signed [EXT_W-1:0] r;
		if (a > PI_X)
			r = a - TWO_PI_X;
		else if (a < -PI_X)
			r = a + TWO_PI_X;
		else
			r = a;
		return r[ANG_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/ihs_front.sv =====
// Front end: takes a quaternion, forms the yaw vector and singularity test with one multiplier.
module ihs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ihs_pkg::item_t  item,
	output logic            q_wr,
	input  logic            q_full,
	output ihs_pkg::vec_t   q_wdata
);

	ihs_pkg::front_state_t state_q, state_nxt;
	ihs_pkg::prod_sel_t    sel_q, psel_q;
	logic                  pv_q;

	logic signed [ihs_pkg::QUAT_WIDTH-1:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [ihs_pkg::QUAT_WIDTH-1:0] opa, opb;
	logic signed [ihs_pkg::PROD_W-1:0]     p_q;
	logic signed [ihs_pkg::VEC_W-1:0]      pe, p2, ag;
	logic signed [ihs_pkg::VEC_W-1:0]      d_q, vx_q, g_q, vy_q;
	logic                                  accept, lock;

	assign accept = push && (state_q == ihs_pkg::F_IDLE);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ihs_pkg::F_IDLE:  if (push) state_nxt = ihs_pkg::F_MUL;
			ihs_pkg::F_MUL:   if (sel_q == ihs_pkg::P_WY) state_nxt = ihs_pkg::F_DRAIN;
			ihs_pkg::F_DRAIN: state_nxt = ihs_pkg::F_CLASS;
			ihs_pkg::F_CLASS: if (!q_full) state_nxt = ihs_pkg::F_IDLE;
			default:          state_nxt = ihs_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full = (state_q != ihs_pkg::F_IDLE);
		q_wr = (state_q == ihs_pkg::F_CLASS) && !q_full;
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (sel_q)
			ihs_pkg::P_WW: begin opa = qw_q; opb = qw_q; end
			ihs_pkg::P_XX: begin opa = qx_q; opb = qx_q; end
			ihs_pkg::P_YY: begin opa = qy_q; opb = qy_q; end
			ihs_pkg::P_ZZ: begin opa = qz_q; opb = qz_q; end
			ihs_pkg::P_XY: begin opa = qx_q; opb = qy_q; end
			ihs_pkg::P_WZ: begin opa = qw_q; opb = qz_q; end
			ihs_pkg::P_XZ: begin opa = qx_q; opb = qz_q; end
			ihs_pkg::P_WY: begin opa = qw_q; opb = qy_q; end
			default:       begin opa = qw_q; opb = qw_q; end
		endcase
	end

	assign pe = ihs_pkg::VEC_W'(p_q);
	assign p2 = pe <<< 1;
	assign ag = g_q[ihs_pkg::VEC_W-1] ? -g_q : g_q;
	assign lock = (ag >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihs_pkg::F_IDLE;
			sel_q   <= ihs_pkg::P_WW;
			pv_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pv_q    <= (state_q == ihs_pkg::F_MUL);
			if (accept)
				sel_q <= ihs_pkg::P_WW;
			else if (state_q == ihs_pkg::F_MUL)
				sel_q <= ihs_pkg::prod_sel_t'(sel_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= item.quat_x;
			qy_q <= item.quat_y;
			qz_q <= item.quat_z;
			qw_q <= item.quat_w;
			d_q  <= '0;
			vx_q <= '0;
			g_q  <= '0;
			vy_q <= '0;
		end else if (pv_q) begin
			case (psel_q) inside
				ihs_pkg::P_WW, ihs_pkg::P_XX: begin
					d_q  <= d_q + pe;
					vx_q <= vx_q + pe;
				end
				ihs_pkg::P_YY, ihs_pkg::P_ZZ: begin
					d_q  <= d_q + pe;
					vx_q <= vx_q - pe;
				end
				ihs_pkg::P_XY, ihs_pkg::P_WZ: vy_q <= vy_q + p2;
				ihs_pkg::P_XZ:                g_q  <= g_q + p2;
				default:                      g_q  <= g_q - p2;
			endcase
		end
		p_q    <= opa * opb;
		psel_q <= sel_q;
	end

	assign q_wdata = '{vx: vx_q, vy: vy_q, lock: lock};

endmodule

// ===== hw/rtl/ihs_queue.sv =====
// Two-entry queue that decouples the front end from the CORDIC back end.
module ihs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ihs_pkg::vec_t wdata,
	output logic          full,
	input  logic          rd,
	output ihs_pkg::vec_t rdata,
	output logic          not_empty
);

	localparam int PTR_W = $clog2(ihs_pkg::QDEPTH);
	localparam int CNT_W = $clog2(ihs_pkg::QDEPTH + 1);

	ihs_pkg::vec_t    mem_q [ihs_pkg::QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full      = (cnt_q == CNT_W'(ihs_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;
	assign rdata     = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == PTR_W'(ihs_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == PTR_W'(ihs_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== hw/rtl/ihs_back.sv =====
// Back end: iterative CORDIC atan2, offset, smoothing filter and result register.
module ihs_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_not_empty,
	input  ihs_pkg::vec_t                      q_rdata,
	output logic                               q_rd,
	input  logic signed [ihs_pkg::ANG_W-1:0]   heading_offset,
	input  logic        [ihs_pkg::GAIN_W-1:0]  smoothing_gain,
	output logic                               out_valid,
	output ihs_pkg::result_t                   out_data,
	input  logic                               pop
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	ihs_pkg::back_state_t state_q, state_nxt;

	logic signed [ihs_pkg::VEC_W-1:0] x_q, y_q, xs, ys;
	logic signed [ihs_pkg::ACC_W-1:0] acc_q, acc_rnd, atan_v;
	logic        [CNT_W-1:0]          cnt_q;
	logic                             lock_q, primed_q, out_valid_q, upd_go, last_step;
	logic signed [ihs_pkg::ANG_W-1:0] yaw_q, diff_q, smooth_q, base;
	logic signed [ihs_pkg::SCL_W-1:0] prod_q, prod_rnd;
	logic signed [ihs_pkg::ANG_W:0]   adj, raw_yaw;
	ihs_pkg::result_t                 res_q;

	assign last_step = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ihs_pkg::B_IDLE:
				if (q_not_empty)
					state_nxt = q_rdata.lock ? ihs_pkg::B_OFFS : ihs_pkg::B_ITER;
			ihs_pkg::B_ITER:  if (last_step) state_nxt = ihs_pkg::B_ROUND;
			ihs_pkg::B_ROUND: state_nxt = ihs_pkg::B_OFFS;
			ihs_pkg::B_OFFS:  state_nxt = ihs_pkg::B_DIFF;
			ihs_pkg::B_DIFF:  state_nxt = ihs_pkg::B_MUL;
			ihs_pkg::B_MUL:   state_nxt = ihs_pkg::B_UPD;
			ihs_pkg::B_UPD:   if (upd_go) state_nxt = ihs_pkg::B_IDLE;
			default:          state_nxt = ihs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_rd   = (state_q == ihs_pkg::B_IDLE) && q_not_empty;
		upd_go = (state_q == ihs_pkg::B_UPD) && (!out_valid_q || pop);
	end

	assign xs       = x_q >>> cnt_q;
	assign ys       = y_q >>> cnt_q;
	assign atan_v   = ihs_pkg::atan_entry(ihs_pkg::TIDX_W'(cnt_q));
	assign acc_rnd  = acc_q + ihs_pkg::ACC_W'(1 << (ihs_pkg::ACC_SHIFT - 1));
	assign raw_yaw  = $signed(acc_rnd[ihs_pkg::ACC_W-1:ihs_pkg::ACC_SHIFT]);
	assign base     = primed_q ? smooth_q : yaw_q;
	assign prod_rnd = prod_q + ihs_pkg::SCL_W'(1 << (ihs_pkg::GAIN_W - 1));
	assign adj      = $signed(prod_rnd[ihs_pkg::SCL_W-1:ihs_pkg::GAIN_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ihs_pkg::B_IDLE;
			primed_q    <= 1'b0;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ihs_pkg::B_DIFF) begin
				primed_q <= 1'b1;
				smooth_q <= base;
			end else if (upd_go) begin
				smooth_q <= ihs_pkg::wrap_angle(ihs_pkg::EXT_W'(smooth_q) + ihs_pkg::EXT_W'(adj));
			end
			if (upd_go)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ihs_pkg::B_IDLE: begin
				cnt_q  <= '0;
				lock_q <= q_rdata.lock;
				yaw_q  <= '0;
				if (q_rdata.vx < 0) begin
					if (q_rdata.vy >= 0) begin
						x_q   <= q_rdata.vy;
						y_q   <= -q_rdata.vx;
						acc_q <= ihs_pkg::HALF_PI_ACC;
					end else begin
						x_q   <= -q_rdata.vy;
						y_q   <= q_rdata.vx;
						acc_q <= -ihs_pkg::HALF_PI_ACC;
					end
				end else begin
					x_q   <= q_rdata.vx;
					y_q   <= q_rdata.vy;
					acc_q <= '0;
				end
			end
			ihs_pkg::B_ITER: begin
				cnt_q <= cnt_q + 1'b1;
				if (y_q > 0) begin
					x_q   <= x_q + ys;
					y_q   <= y_q - xs;
					acc_q <= acc_q + atan_v;
				end else begin
					x_q   <= x_q - ys;
					y_q   <= y_q + xs;
					acc_q <= acc_q - atan_v;
				end
			end
			ihs_pkg::B_ROUND:
				yaw_q <= ihs_pkg::wrap_angle(ihs_pkg::EXT_W'(raw_yaw));
			ihs_pkg::B_OFFS:
				yaw_q <= ihs_pkg::wrap_angle(ihs_pkg::EXT_W'(yaw_q) +
					ihs_pkg::EXT_W'(heading_offset));
			ihs_pkg::B_DIFF:
				diff_q <= ihs_pkg::wrap_angle(ihs_pkg::EXT_W'(yaw_q) - ihs_pkg::EXT_W'(base));
			ihs_pkg::B_MUL:
				prod_q <= $signed({1'b0, smoothing_gain}) * diff_q;
			default: ;
		endcase
		if (upd_go) begin
			res_q.heading     <= ihs_pkg::wrap_angle(ihs_pkg::EXT_W'(smooth_q) +
				ihs_pkg::EXT_W'(adj));
			res_q.gimbal_lock <= lock_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

// ===== hw/rtl/imu_heading_smoother.sv =====
// Top level of the IMU heading smoother: config registers, front end, queue, back end.
//
// Takes one orientation quaternion (signed Q1.14) per word and returns one word with the
// smoothed compass heading (signed Q2.13 radians, always in [-pi, pi]) and a gimbal_lock
// flag. Yaw is atan2(2(xy+wz), w^2+x^2-y^2-z^2) from a CORDIC of CORDIC_STEPS iterations;
// when |2(xz-wy)| >= w^2+x^2+y^2+z^2 (pitch singularity, also the all-zero quaternion)
// the raw yaw is forced to 0 and gimbal_lock is set. heading_offset (register 0) is added
// and the sum wrapped; the first word after reset seeds the filter, then each word moves
// the heading by smoothing_gain (register 1, Q0.16) times the wrapped difference, rounded
// to nearest. Write config only while the block is idle.
// The front end takes a word, forms 8 products through one multiplier, accumulates and
// classifies; the back end reads the word from the queue, runs the CORDIC loop and rounds
// (both skipped for a gimbal-lock word), adds the offset, forms the difference, scales it
// and updates. Each half works on one word at a time. For ordinary words the back end's
// CORDIC loop sets the sustained rate; a run of gimbal-lock words goes at the front end's
// rate. A two-word queue sits between the halves, and the result register lets the next
// word proceed while a result waits.
module imu_heading_smoother #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  ihs_pkg::item_t                   item,
	output logic                             empty,
	input  logic                             pop,
	output ihs_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [ihs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ihs_pkg::CFG_W-1:0]        cfg_wdata
);

	logic signed [ihs_pkg::ANG_W-1:0]  heading_offset_q;
	logic        [ihs_pkg::GAIN_W-1:0] smoothing_gain_q;

	logic          q_wr, q_full, q_rd, q_not_empty, out_valid;
	ihs_pkg::vec_t q_wdata, q_rdata;

	// config registers: plain write port, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_offset_q <= ihs_pkg::OFFSET_RESET;
			smoothing_gain_q <= ihs_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (ihs_pkg::reg_idx_t'(cfg_idx))
				ihs_pkg::REG_HEADING_OFFSET: heading_offset_q <= $signed(cfg_wdata);
				ihs_pkg::REG_SMOOTHING_GAIN: smoothing_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: products and singularity test
	ihs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_wr    (q_wr),
		.q_full  (q_full),
		.q_wdata (q_wdata)
	);

	// decoupling queue
	ihs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_wr),
		.wdata     (q_wdata),
		.full      (q_full),
		.rd        (q_rd),
		.rdata     (q_rdata),
		.not_empty (q_not_empty)
	);

	// back: CORDIC, offset, smoothing, result register
	ihs_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_rdata        (q_rdata),
		.q_rd           (q_rd),
		.heading_offset (heading_offset_q),
		.smoothing_gain (smoothing_gain_q),
		.out_valid      (out_valid),
		.out_data       (result),
		.pop            (pop)
	);

	assign empty = !out_valid;

`ifndef SYNTHESIS
	// front never writes a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_wr |-> !q_full)
		else $error("front wrote into a full queue");

	// back only takes a word that is there
	assert property (@(posedge clk) disable iff (!arst_n) q_rd |-> q_not_empty)
		else $error("back read an empty queue");

	// a delivered heading is always wrapped
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.heading <= 16'sd25736 && result.heading >= -16'sd25736))
		else $error("heading out of range");
`endif

endmodule

// ===== tb/tb_imu_heading_smoother.sv =====
// Self-checking testbench for the IMU heading smoother: random and directed words, own predictor.
`timescale 1ns / 1ps

module tb_imu_heading_smoother;

	// Angle scale: Q2.13 radians, CORDIC accumulator in radians * 2^24
	localparam int     PI_Q13    = 25736;
	localparam int     TURN_Q13  = 2 * PI_Q13;
	localparam longint QUARTER_ACC = 64'sd26353589;
	localparam int     CORDIC_N  = 16;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     LONG_HOLD = 300;      // receiver hold-off long enough to back up the input

	localparam longint ARCTAN_Q24 [24] = '{
		64'sd13176795, 64'sd7778716, 64'sd4110060, 64'sd2086331, 64'sd1047214, 64'sd524117,
		64'sd262123, 64'sd131069, 64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
		64'sd4096, 64'sd2048, 64'sd1024, 64'sd512, 64'sd256, 64'sd128,
		64'sd64, 64'sd32, 64'sd16, 64'sd8, 64'sd4, 64'sd2
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	ihs_pkg::item_t                 item = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	ihs_pkg::result_t               result;
	logic                           cfg_we = 1'b0;
	logic [ihs_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [ihs_pkg::CFG_W-1:0]      cfg_wdata = '0;

	// Predictor copy of the block's registers and filter state
	int offset_q13 = -25736;
	int gain_q16   = 3277;
	int heading_q13 = 0;
	bit seeded     = 1'b0;

	ihs_pkg::item_t   quat_backlog [$];   // words waiting for the driver
	ihs_pkg::result_t heading_due  [$];   // predicted results, oldest first
	int      quats_sent  = 0;
	int      quats_taken = 0;
	int      error_count = 0;

	bit word_in_taken = 1'b0;    // input handshake seen at the last rising edge
	bit tx_idle_on    = 1'b1;
	bit rx_idle_on    = 1'b1;
	bit rx_long_hold  = 1'b0;
	int tx_gap_left   = 0;
	int rx_stall_left = 0;

	imu_heading_smoother uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Fold into [-pi, pi] by whole turns
	function automatic int fold_angle(int a);
		while (a > PI_Q13)
			a -= TURN_Q13;
		while (a < -PI_Q13)
			a += TURN_Q13;
		return a;
	endfunction

	// Steps the smoothing filter by one quaternion and returns the word the block should emit
	function automatic ihs_pkg::result_t advance_heading(ihs_pkg::item_t q);
		longint qx, qy, qz, qw, g, ag, d, vx, vy, nx, ny, acc, adj;
		int yaw, diff;
		ihs_pkg::result_t r;
		qx = q.quat_x;
		qy = q.quat_y;
		qz = q.quat_z;
		qw = q.quat_w;
		g  = 2 * (qx * qz - qw * qy);
		d  = qw * qw + qx * qx + qy * qy + qz * qz;
		ag = (g < 0) ? -g : g;
		if (ag >= d) begin
			// pitch singularity (zero quaternion included): yaw forced to zero
			r.gimbal_lock = 1'b1;
			yaw = 0;
		end else begin
			r.gimbal_lock = 1'b0;
			vy  = 2 * (qx * qy + qw * qz);
			vx  = qw * qw + qx * qx - qy * qy - qz * qz;
			acc = 0;
			// left half plane: pre-rotate a quarter turn toward the positive x axis
			if (vx < 0) begin
				if (vy >= 0) begin
					nx = vy;
					ny = -vx;
					acc = QUARTER_ACC;
				end else begin
					nx = -vy;
					ny = vx;
					acc = -QUARTER_ACC;
				end
				vx = nx;
				vy = ny;
			end
			for (int i = 0; i < CORDIC_N && i < 24; i++) begin
				if (vy > 0) begin
					nx = vx + (vy >>> i);
					ny = vy - (vx >>> i);
					acc += ARCTAN_Q24[i];
				end else begin
					nx = vx - (vy >>> i);
					ny = vy + (vx >>> i);
					acc -= ARCTAN_Q24[i];
				end
				vx = nx;
				vy = ny;
			end
			yaw = fold_angle(int'((acc + 64'sd1024) >>> 11));
		end
		yaw = fold_angle(yaw + offset_q13);
		// first word after reset seeds the filter
		if (!seeded) begin
			heading_q13 = yaw;
			seeded = 1'b1;
		end
		diff = fold_angle(yaw - heading_q13);
		adj  = (longint'(gain_q16) * longint'(diff) + 64'sd32768) >>> 16;
		heading_q13 = fold_angle(heading_q13 + int'(adj));
		r.heading = heading_q13[15:0];
		return r;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_component();
		int r;
		r = $urandom_range(0, 4);
		case (r)
			0: return -32768;
			1: return -16384;
			2: return 0;
			3: return 16384;
			default: return 32767;
		endcase
	endfunction

	// Random quaternion: mostly in-range orientations, plus raw bit patterns,
	// singular poses (exact and nudged off the boundary), tiny and extreme components
	function automatic ihs_pkg::item_t random_quat();
		ihs_pkg::item_t q;
		int a, b, kind;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			q.quat_x = 16'($urandom_range(0, 32768) - 16384);
			q.quat_y = 16'($urandom_range(0, 32768) - 16384);
			q.quat_z = 16'($urandom_range(0, 32768) - 16384);
			q.quat_w = 16'($urandom_range(0, 32768) - 16384);
		end else if (kind < 70) begin
			q = ihs_pkg::item_t'({$urandom, $urandom});
		end else if (kind < 82) begin
			// x = -z, y = w makes |g| equal to d exactly
			a = $urandom_range(0, 32768) - 16384;
			b = $urandom_range(0, 32768) - 16384;
			q.quat_x = 16'(-b + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) - 3 : 0));
			q.quat_y = 16'(a);
			q.quat_z = 16'(b);
			q.quat_w = 16'(a + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) - 3 : 0));
			if ($urandom_range(0, 1) == 1) begin
				q.quat_y = 16'(-a);
				q.quat_x = 16'(b);
			end
		end else if (kind < 92) begin
			q.quat_x = 16'($urandom_range(0, 8) - 4);
			q.quat_y = 16'($urandom_range(0, 8) - 4);
			q.quat_z = 16'($urandom_range(0, 8) - 4);
			q.quat_w = 16'($urandom_range(0, 8) - 4);
		end else begin
			q.quat_x = 16'(pick_component());
			q.quat_y = 16'(pick_component());
			q.quat_z = 16'(pick_component());
			q.quat_w = 16'(pick_component());
		end
		return q;
	endfunction

	// Input driver: holds a word until taken, then idles for the gap drawn with it
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !word_in_taken) begin
			// still offered, block is full
		end else if (tx_gap_left > 0) begin
			push <= 1'b0;
			tx_gap_left = tx_gap_left - 1;
		end else if (quat_backlog.size() != 0) begin
			item <= quat_backlog.pop_front();
			push <= 1'b1;
			tx_gap_left = tx_idle_on ? pick_gap() : 0;
		end else begin
			push <= 1'b0;
		end
	end

	// Result side: pop mostly high, random stalls, one long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_stall_left > 0) begin
			pop <= 1'b0;
			rx_stall_left = rx_stall_left - 1;
		end else if (rx_long_hold) begin
			rx_long_hold = 1'b0;
			rx_stall_left = LONG_HOLD - 1;
			pop <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall_left = pick_gap();
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Monitor: mirrors register writes, predicts on input handshakes, checks results
	always @(posedge clk) begin
		ihs_pkg::result_t want;
		word_in_taken <= arst_n && push && !full;
		if (arst_n) begin
			if (cfg_we) begin
				case (ihs_pkg::reg_idx_t'(cfg_idx))
					ihs_pkg::REG_HEADING_OFFSET: offset_q13 = int'($signed(cfg_wdata));
					ihs_pkg::REG_SMOOTHING_GAIN: gain_q16   = int'(cfg_wdata);
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (heading_due.size() == 0) begin
					$display("%0t: unexpected result word heading=%0d gimbal_lock=%0b",
						$time, $signed(result.heading), result.gimbal_lock);
					error_count++;
				end else begin
					want = heading_due.pop_front();
					if (result.heading !== want.heading) begin
						$display("%0t: heading mismatch: expected %0d, actual %0d",
							$time, $signed(want.heading), $signed(result.heading));
						error_count++;
					end
					if (result.gimbal_lock !== want.gimbal_lock) begin
						$display("%0t: gimbal_lock mismatch: expected %0b, actual %0b",
							$time, want.gimbal_lock, result.gimbal_lock);
						error_count++;
					end
				end
			end
			if (push && !full) begin
				heading_due.push_back(advance_heading(item));
				quats_taken++;
			end
		end
	end

	task automatic add_quat(int x, int y, int z, int w);
		ihs_pkg::item_t q;
		q.quat_x = 16'(x);
		q.quat_y = 16'(y);
		q.quat_z = 16'(z);
		q.quat_w = 16'(w);
		quat_backlog.push_back(q);
		quats_sent++;
	endtask

	// Every queued word taken and every predicted result delivered
	task automatic wait_drained();
		@(negedge clk);
		while (quats_taken != quats_sent || heading_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(ihs_pkg::reg_idx_t idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value[15:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One configuration setting followed by a batch of random words
	task automatic run_setting(int offs, int gain, int n_words, bit tx_idle, bit rx_idle,
			bit hold_rx);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(ihs_pkg::REG_HEADING_OFFSET, offs);
		write_reg(ihs_pkg::REG_SMOOTHING_GAIN, gain);
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		@(posedge clk);
		for (int n = 0; n < n_words; n++)
			quat_backlog.push_back(random_quat());
		quats_sent += n_words;
		if (hold_rx)
			rx_long_hold = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed words at reset configuration; the first one seeds the filter
		add_quat(0, 0, 0, 16384);             // identity, yaw 0
		add_quat(0, 0, 0, 0);                 // zero quaternion takes the singular path
		add_quat(0, 11585, 0, 11585);         // pitch +90: gimbal lock
		add_quat(0, -11585, 0, 11585);        // pitch -90: gimbal lock
		add_quat(0, 0, 16384, 0);             // yaw pi, x < 0 with y = 0
		add_quat(0, 0, 16384, -1);            // yaw just past -pi, y < 0 pre-rotation
		add_quat(0, 0, 11585, 11585);         // yaw +90
		add_quat(0, 0, -11585, 11585);        // yaw -90
		add_quat(0, 0, 15137, -6270);         // yaw about -135
		add_quat(0, 0, 1, 1);                 // unnormalized, tiny scale
		add_quat(0, 0, 3, -1);                // unnormalized, tiny, left half plane
		add_quat(-32768, -32768, -32768, -32768);
		add_quat(32767, 32767, 32767, 32767);
		add_quat(-16384, -16384, -16384, -16384);
		add_quat(16384, 16384, 16384, 16384);
		add_quat(16384, -16384, 16384, -16384);
		add_quat(32767, 0, 0, -32768);        // components beyond one, roll quarter turn
		add_quat(0, -32768, 0, 0);
		add_quat(0, 0, -32768, 32767);
		add_quat(-32768, 32767, 0, 0);
		add_quat(1, -1, 1, -1);
		add_quat(5000, -3000, 12000, -9000);

		// Extreme settings; the first holds off the receiver so the input backs up
		run_setting(25736, 65535, 250, 1'b0, 1'b0, 1'b1);
		run_setting(0, 0, 150, 1'b1, 1'b1, 1'b0);
		run_setting(-25736, 1, 150, 1'b1, 1'b1, 1'b0);
		run_setting(-25736, 65535, 100, 1'b1, 1'b0, 1'b0);
		// Random settings, one stretch with no idling on either side
		for (int k = 0; k < 5; k++)
			run_setting(int'($urandom_range(0, TURN_Q13)) - PI_Q13,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535),
				230, (k != 2), (k != 2), (k == 4));

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog well beyond the slowest legal run
	initial begin
		#12_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
